/* src/lfce_pkg.sv */
// ----------------------------------------------------------------------------
// lfce_pkg
// Shared constants, codes and request and response structs for the LED fade curve engine.
// ----------------------------------------------------------------------------
package lfce_pkg;

  localparam int CURVE_SIZE = 256;
  localparam int NUM_LEDS   = 16;
  localparam int MAX_DRIVEN = 16;

  localparam int CURVE_AW  = $clog2(CURVE_SIZE);
  localparam int DRIVE_MAX = (NUM_LEDS < MAX_DRIVEN) ? NUM_LEDS : MAX_DRIVEN;
  localparam int LED_AW    = (DRIVE_MAX > 1) ? $clog2(DRIVE_MAX) : 1;
  localparam int LED_CW    = $clog2(DRIVE_MAX + 1);

  localparam int LEVEL_W   = 16;
  localparam int FADE_W    = 24;
  localparam int ELAPSED_W = 32;
  localparam int TICK_W    = 16;
  localparam int COUNT_W   = 5;
  localparam int NUM_W     = FADE_W + CURVE_AW;

  // input item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_FADE   = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [FADE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic               busy;
    logic [CURVE_AW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] from_lvl;
    logic [LEVEL_W-1:0] to_lvl;
    logic [LEVEL_W-1:0] weight;
  } blend_req_t;

endpackage

/* src/lfce_div.sv */
// ----------------------------------------------------------------------------
// lfce_div
// Restoring divider, one quotient bit per cycle, for the curve index.
// ----------------------------------------------------------------------------
module lfce_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lfce_pkg::div_req_t req,
  output lfce_pkg::div_rsp_t rsp
);
  import lfce_pkg::*;

  localparam int CNT_W = $clog2(CURVE_AW + 1);

  logic [FADE_W-1:0]   rem_r;
  logic [FADE_W-1:0]   den_r;
  logic [CURVE_AW-1:0] shq_r;   // low numerator bits in, quotient bits out
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;

  logic [FADE_W:0]     trial;
  logic                take;

  assign trial = {rem_r, shq_r[CURVE_AW-1]};
  assign take  = trial >= {1'b0, den_r};

  // numerator is below den * 2^CURVE_AW, so the upper part starts below den
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == CNT_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(CURVE_AW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1))
          busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num[NUM_W-1:CURVE_AW];
      shq_r <= req.num[CURVE_AW-1:0];
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= take ? FADE_W'(trial - {1'b0, den_r}) : trial[FADE_W-1:0];
      shq_r <= {shq_r[CURVE_AW-2:0], take};
    end
  end

  assign rsp.done = done_r;
  assign rsp.busy = busy_r;
  assign rsp.quo  = shq_r;

endmodule

/* src/lfce_blend.sv */
// ----------------------------------------------------------------------------
// lfce_blend
// Two-stage blend: start + (target - start) * w, rounded, divided by 65535.
// ----------------------------------------------------------------------------
module lfce_blend (
  input  logic                        clk,
  input  lfce_pkg::blend_req_t         req,
  output logic [lfce_pkg::LEVEL_W-1:0] level
);
  import lfce_pkg::*;

  logic signed [16:0] diff;
  logic signed [16:0] wgt;
  logic signed [33:0] prod_r;
  logic [LEVEL_W-1:0] from_r;
  logic signed [34:0] sum;
  logic [31:0]        sum_r;
  logic [15:0]        q0;
  logic [16:0]        r0;

  assign diff = $signed({1'b0, req.to_lvl}) - $signed({1'b0, req.from_lvl});
  assign wgt  = $signed({1'b0, req.weight});

  // from*65535 + (to - from)*w + 32767, never negative
  assign sum = $signed({3'b000, from_r, 16'h0000}) - $signed({19'd0, from_r})
             + 35'(prod_r) + 35'sd32767;

  always_ff @(posedge clk) begin
    prod_r <= diff * wgt;
    from_r <= req.from_lvl;
    sum_r  <= sum[31:0];
  end

  // x / 65535: x>>16 undershoots by at most one
  assign q0    = sum_r[31:16];
  assign r0    = {1'b0, sum_r[15:0]} + {1'b0, q0};
  assign level = (r0 >= 17'd65535) ? q0 + 16'd1 : q0;

endmodule

/* src/led_fade_curve_engine_top.sv */
// ----------------------------------------------------------------------------
// led_fade_curve_engine_top
// Fades up to 16 LEDs toward a target level along a loaded easing curve.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | tuser kind, tdata tick/addr/level
//  out_    | master    | out_tvalid/out_tready| tuser led_valid, tdata, tlast
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  A tick that drives LEDs passes a compare, the serial divider (one quotient
//  bit per cycle) unless the fade is over, a curve read, then the multiply,
//  sum and emit states for each LED through the shared blend multiplier.
//  Other requests pass through the status state alone.
//  Input is taken only while the sequencer is idle; a stalled output holds
//  the sequencer. cfg_ready is always high. Reset is synchronous, active low,
//  and clears LED levels, elapsed time and the running flag; the curve
//  memory is not cleared.
// ----------------------------------------------------------------------------
module led_fade_curve_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  // input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // tick_ms[15:0], curve_addr[23:16], curve_level[39:24]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // led_number[3:0], level[19:4], running[20], zero[23:21]
  output logic [0:0]  out_tuser,  // led_valid[0]
  output logic        out_tlast,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import lfce_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_STAT, ST_CMP, ST_DIV, ST_RD, ST_MUL, ST_SUM, ST_EMIT
  } state_t;

  state_t state_r;

  // configuration
  logic [LEVEL_W-1:0] target_r;
  logic [FADE_W-1:0]  fade_r;
  logic [COUNT_W-1:0] count_r;

  // fade state
  logic [ELAPSED_W-1:0] elapsed_r;
  logic                 running_r;
  logic [LEVEL_W-1:0]   led_lvl_r   [NUM_LEDS];
  logic [LEVEL_W-1:0]   start_lvl_r [NUM_LEDS];

  // curve memory, read data registered
  logic [LEVEL_W-1:0]  curve_mem [CURVE_SIZE];
  logic [LEVEL_W-1:0]  curve_w_r;
  logic [CURVE_AW-1:0] idx_r;

  // sequencing
  logic [LED_CW-1:0] n_r;
  logic [LED_AW-1:0] led_idx_r;

  // output register
  logic               out_valid_r;
  logic               out_led_r;
  logic [3:0]         out_num_r;
  logic [LEVEL_W-1:0] out_lvl_r;
  logic               out_run_r;
  logic               out_last_r;

  // request fields
  logic [1:0]         kind;
  logic [TICK_W-1:0]  tick_ms;
  logic [7:0]         curve_addr;
  logic [LEVEL_W-1:0] curve_level;

  logic                 in_acc;
  logic                 out_free;
  logic                 out_load;
  logic [LED_CW-1:0]    n_lim;
  logic [ELAPSED_W:0]   tick_sum;
  logic [ELAPSED_W-1:0] elapsed_sat;
  logic                 led_last;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  blend_req_t         blend_req;
  logic [LEVEL_W-1:0] blend_lvl;

  assign kind        = in_tuser;
  assign tick_ms     = in_tdata[15:0];
  assign curve_addr  = in_tdata[23:16];
  assign curve_level = in_tdata[39:24];

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // a result is loaded from the status or the emit state
  assign out_load = ((state_r == ST_STAT) || (state_r == ST_EMIT)) && out_free;

  // drive count limited to the LEDs that exist
  assign n_lim = (32'(count_r) > DRIVE_MAX) ? LED_CW'(DRIVE_MAX) : LED_CW'(count_r);

  assign tick_sum    = {1'b0, elapsed_r} + (ELAPSED_W + 1)'(tick_ms);
  assign elapsed_sat = tick_sum[ELAPSED_W] ? '1 : tick_sum[ELAPSED_W-1:0];

  assign led_last = (LED_CW'(led_idx_r) + LED_CW'(1)) == n_r;

  // index = (CURVE_SIZE-1) * elapsed / fade; only reached with elapsed < fade
  assign div_req.start = (state_r == ST_CMP) && (elapsed_r < ELAPSED_W'(fade_r));
  assign div_req.num   = NUM_W'(elapsed_r[FADE_W-1:0]) * NUM_W'(CURVE_SIZE - 1);
  assign div_req.den   = fade_r;

  assign blend_req.from_lvl = start_lvl_r[led_idx_r];
  assign blend_req.to_lvl   = target_r;
  assign blend_req.weight   = curve_w_r;

  lfce_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lfce_blend u_blend (
    .clk   (clk),
    .req   (blend_req),
    .level (blend_lvl)
  );

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      fade_r   <= '0;
      count_r  <= COUNT_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TARGET: target_r <= cfg_data[LEVEL_W-1:0];
        REG_FADE:   fade_r   <= cfg_data[FADE_W-1:0];
        REG_COUNT:  count_r  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // curve memory
  always_ff @(posedge clk) begin
    if (in_acc && kind == KIND_WRITE && 32'(curve_addr) < CURVE_SIZE)
      curve_mem[CURVE_AW'(curve_addr)] <= curve_level;
    curve_w_r <= curve_mem[idx_r];
  end

  // sequencer, fade state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      elapsed_r   <= '0;
      running_r   <= 1'b0;
      n_r         <= '0;
      led_idx_r   <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      out_led_r   <= 1'b0;
      out_num_r   <= '0;
      out_lvl_r   <= '0;
      out_run_r   <= 1'b0;
      out_last_r  <= 1'b0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        led_lvl_r[i]   <= '0;
        start_lvl_r[i] <= '0;
      end
    end else begin
      if (out_load)
        out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready)
        out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            n_r       <= n_lim;
            led_idx_r <= '0;
            if (kind == KIND_START) begin
              for (int i = 0; i < NUM_LEDS; i++)
                start_lvl_r[i] <= led_lvl_r[i];
              elapsed_r <= '0;
              running_r <= 1'b1;
              state_r   <= ST_STAT;
            end else if (kind == KIND_TICK && running_r && tick_ms != '0 &&
                         n_lim != '0) begin
              elapsed_r <= elapsed_sat;
              state_r   <= ST_CMP;
            end else begin
              state_r <= ST_STAT;
            end
          end
        end
        ST_STAT: begin
          if (out_free) begin
            out_led_r   <= 1'b0;
            out_num_r   <= '0;
            out_lvl_r   <= '0;
            out_run_r   <= running_r;
            out_last_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        ST_CMP: begin
          // zero fade time lands here too: elapsed is never below zero
          if (elapsed_r >= ELAPSED_W'(fade_r)) begin
            idx_r     <= CURVE_AW'(CURVE_SIZE - 1);
            running_r <= 1'b0;
            state_r   <= ST_RD;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            idx_r   <= div_rsp.quo;
            state_r <= ST_RD;
          end
        end
        ST_RD:  state_r <= ST_MUL;
        ST_MUL: state_r <= ST_SUM;
        ST_SUM: state_r <= ST_EMIT;
        ST_EMIT: begin
          if (out_free) begin
            out_led_r            <= 1'b1;
            out_num_r            <= 4'(led_idx_r);
            out_lvl_r            <= blend_lvl;
            out_run_r            <= running_r;
            out_last_r           <= led_last;
            led_lvl_r[led_idx_r] <= blend_lvl;
            if (led_last) begin
              state_r <= ST_IDLE;
            end else begin
              led_idx_r <= led_idx_r + LED_AW'(1);
              state_r   <= ST_MUL;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_run_r, out_lvl_r, out_num_r};
  assign out_tuser  = out_led_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // the index from the divider stays below the clamped end entry
  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (32'(div_rsp.quo) < CURVE_SIZE - 1))
    else $error("divider quotient reached the clamp value");

  // a new request never arrives while a division is in flight
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !div_rsp.busy)
    else $error("request taken while divider busy");

  // status results are single, empty and final
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tlast && out_tdata[19:0] == 20'd0))
    else $error("malformed status result");
`endif

endmodule
